### design/pattern_stereogram_row_builder_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the row builder modules.
// Both use the local clk and rst of the module they appear in.
// ---------------------------------------------------------------------------
`ifndef PATTERN_STEREOGRAM_ROW_BUILDER_DEFINES_SVH
`define PATTERN_STEREOGRAM_ROW_BUILDER_DEFINES_SVH

// Same-cycle implication.
`define PSRB_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSRB_CHECK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/psrb_pkg.sv
// ---------------------------------------------------------------------------
// psrb_pkg
// Types, codes and helpers shared by the stereogram row builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psrb_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_BITS    = 10;
  localparam int TILE_SIDE   = 64;
  localparam int TILE_BITS   = 6;
  localparam int TEX_BITS    = 2 * TILE_BITS;
  localparam int RGB_BITS    = 24;
  localparam int DIV_N_BITS  = 12;
  localparam int DIV_D_BITS  = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  localparam logic [2:0] CMD_LOAD_BG = 3'd0;
  localparam logic [2:0] CMD_LOAD_FG = 3'd1;
  localparam logic [2:0] CMD_START   = 3'd2;
  localparam logic [2:0] CMD_DEPTH   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_MAX_OFFSET = 3'd1;
  localparam logic [2:0] REG_IMG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_BG_WIDTH   = 3'd3;
  localparam logic [2:0] REG_BG_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_FG_WIDTH   = 3'd5;
  localparam logic [2:0] REG_FG_HEIGHT  = 3'd6;

  typedef enum logic [2:0] {
    OP_BG_WR,
    OP_FG_WR,
    OP_CLEAR,
    OP_PAINT,
    OP_READ,
    OP_READ_ZERO
  } op_kind_t;

  // One unit of work for the back end.
  typedef struct packed {
    op_kind_t              kind;
    logic [RGB_BITS-1:0]   color;
    logic [TEX_BITS-1:0]   tex_a;     // texel for left view, or tile write address
    logic [TEX_BITS-1:0]   tex_b;     // texel for right view
    logic                  left_en;
    logic                  right_en;
    logic [COL_BITS-1:0]   left_col;  // also the column of a read
    logic [COL_BITS-1:0]   right_col;
  } op_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_N_BITS-1:0] dividend;
    logic [DIV_D_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIV_N_BITS-1:0] quot;
    logic [DIV_D_BITS-1:0] rem;
  } div_rsp_t;

  // Tile side: zero acts as one, anything above the tile acts as the tile.
  function automatic logic [6:0] clamp_side(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > 7'(TILE_SIDE)) r = 7'(TILE_SIDE);
    return r;
  endfunction

endpackage

`default_nettype wire

### design/pattern_stereogram_row_builder.sv
// ---------------------------------------------------------------------------
// pattern_stereogram_row_builder
// Builds one row of left/right pattern stereogram views from depth pixels.
// ---------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  cfg      | cfg_valid / cfg_ready    | cfg_index[2:0], cfg_data[10:0]
//  item     | item_valid / item_stall  | command, column, row, color
//  result   | result_valid/result_stall| left_color, right_color
//
//  The front takes one item at a time and runs its divisions one after
//  another on the shared 12-bit divider: up to five for a depth pixel,
//  up to two for a read, none for a texel load or start row.
//  The back runs one paint or read at a time, and sweeps all 1024 row
//  entries after reset and after every start row.
//  A stalled result holds the back; the 4-entry queue then fills and stalls
//  the item channel. Reset is synchronous and active high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pattern_stereogram_row_builder import psrb_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [10:0]         cfg_data,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire logic [2:0]          command,
  input  wire logic [COL_BITS-1:0] column,
  input  wire logic [11:0]         row,
  input  wire logic [RGB_BITS-1:0] color,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [RGB_BITS-1:0]      left_color,
  output logic [RGB_BITS-1:0]      right_color
);

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  op_t  push_op;
  op_t  head;

  psrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .column     (column),
    .row        (row),
    .color      (color),
    .push       (push),
    .push_op    (push_op),
    .q_full     (q_full)
  );

  psrb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  psrb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .left_color   (left_color),
    .right_color  (right_color)
  );

endmodule

`default_nettype wire

### design/psrb_div.sv
// ---------------------------------------------------------------------------
// psrb_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psrb_div import psrb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [3:0]            cnt;
  logic                  busy;
  logic                  done;
  logic [DIV_N_BITS-1:0] q;
  logic [DIV_D_BITS-1:0] acc;
  logic [DIV_D_BITS-1:0] dsr;
  logic [DIV_N_BITS-1:0] trial;
  logic [DIV_N_BITS-1:0] diff;
  logic                  fit;

  assign trial = {acc, q[DIV_N_BITS-1]};
  assign fit   = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 4'(DIV_N_BITS);
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      q   <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      acc <= fit ? diff[DIV_D_BITS-1:0] : trial[DIV_D_BITS-1:0];
      q   <= {q[DIV_N_BITS-2:0], fit};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem  = acc;

endmodule

`default_nettype wire

### design/psrb_front.sv
// ---------------------------------------------------------------------------
// psrb_front
// Takes items and configuration, works out disparity and tile texel
// coordinates with a shared divider, and queues at most one op per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pattern_stereogram_row_builder_defines.svh"

module psrb_front import psrb_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [10:0]         cfg_data,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire logic [2:0]          command,
  input  wire logic [COL_BITS-1:0] column,
  input  wire logic [11:0]         row,
  input  wire logic [RGB_BITS-1:0] color,
  output logic                     push,
  output op_t                      push_op,
  input  wire logic                q_full
);

  typedef enum logic [6:0] {
    F_IDLE   = 7'b0000001,
    F_SCALE  = 7'b0000010,
    F_DISP   = 7'b0000100,
    F_COLX   = 7'b0001000,
    F_SHIFTX = 7'b0010000,
    F_ROWY   = 7'b0100000,
    F_PUSH   = 7'b1000000
  } fstate_t;

  fstate_t state;
  fstate_t state_next;

  logic        mode;
  logic [7:0]  max_offset;
  logic [10:0] image_width;
  logic [6:0]  bg_width;
  logic [6:0]  bg_height;
  logic [6:0]  fg_width;
  logic [6:0]  fg_height;

  logic [2:0]          cmd_r;
  logic [COL_BITS-1:0] col_r;
  logic [TILE_BITS-1:0] row_r;
  logic [RGB_BITS-1:0] color_r;
  logic                in_range_r;
  logic [11:0]         cur_row;
  logic [7:0]          divq;
  logic [7:0]          disp;
  logic [TILE_BITS-1:0] colx;
  logic [TILE_BITS-1:0] shiftx;
  logic [TILE_BITS-1:0] rowy;
  logic                started;

  logic [10:0] w_eff;
  logic [7:0]  mo_eff;
  logic [6:0]  side_w;
  logic [6:0]  side_h;
  logic        accept;
  logic        in_range;
  logic        div_state;
  logic [12:0] gray_sum;
  logic [7:0]  gray;
  logic [7:0]  ol;
  logic [7:0]  orr;
  logic [10:0] lsum;

  div_req_t div_req;
  div_rsp_t div_rsp;

  psrb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      max_offset  <= 8'd10;
      image_width <= 11'd1024;
      bg_width    <= 7'd64;
      bg_height   <= 7'd64;
      fg_width    <= 7'd64;
      fg_height   <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:       mode        <= cfg_data[0];
        REG_MAX_OFFSET: max_offset  <= cfg_data[7:0];
        REG_IMG_WIDTH:  image_width <= cfg_data;
        REG_BG_WIDTH:   bg_width    <= cfg_data[6:0];
        REG_BG_HEIGHT:  bg_height   <= cfg_data[6:0];
        REG_FG_WIDTH:   fg_width    <= cfg_data[6:0];
        REG_FG_HEIGHT:  fg_height   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign w_eff  = (image_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width;
  assign mo_eff = (max_offset == 8'd0) ? 8'd1 : max_offset;
  assign side_w = clamp_side((cmd_r == CMD_READ) ? bg_width : fg_width);
  assign side_h = clamp_side((cmd_r == CMD_READ) ? bg_height : fg_height);

  assign item_stall = (state != F_IDLE);
  assign accept     = item_valid && !item_stall;
  assign in_range   = {1'b0, column} < w_eff;

  assign gray_sum = 13'd11 * {5'd0, color_r[23:16]} + {1'b0, color_r[15:8], 4'd0}
                  + 13'd5 * {5'd0, color_r[7:0]};
  assign gray     = gray_sum[12:5];

  assign div_state = (state == F_SCALE) || (state == F_DISP) || (state == F_COLX)
                  || (state == F_SHIFTX) || (state == F_ROWY);

  always_comb begin
    div_req.start    = div_state && !started;
    div_req.dividend = {4'd0, 8'd255};
    div_req.divisor  = {3'd0, mo_eff};
    unique case (state)
      F_DISP: begin
        div_req.dividend = {3'd0, gray, 1'b0} + {4'd0, divq};
        div_req.divisor  = {2'd0, divq, 1'b0};
      end
      F_COLX: begin
        div_req.dividend = {2'd0, col_r};
        div_req.divisor  = {4'd0, side_w};
      end
      F_SHIFTX: begin
        div_req.dividend = {2'd0, col_r} + {4'd0, disp};
        div_req.divisor  = {4'd0, side_w};
      end
      F_ROWY: begin
        div_req.dividend = cur_row;
        div_req.divisor  = {4'd0, side_h};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_LOAD_BG, CMD_LOAD_FG:
              if (column < 10'(TILE_SIDE) && row < 12'(TILE_SIDE)) state_next = F_PUSH;
            CMD_START: state_next = F_PUSH;
            CMD_DEPTH: if (in_range) state_next = F_SCALE;
            CMD_READ:  state_next = in_range ? F_COLX : F_PUSH;
            default: ;
          endcase
        end
      end
      F_SCALE:  if (div_rsp.done) state_next = F_DISP;
      F_DISP:   if (div_rsp.done) state_next = (div_rsp.quot == '0) ? F_IDLE : F_COLX;
      F_COLX: begin
        if (div_rsp.done) begin
          state_next = (cmd_r == CMD_DEPTH && mode) ? F_SHIFTX : F_ROWY;
        end
      end
      F_SHIFTX: if (div_rsp.done) state_next = F_ROWY;
      F_ROWY:   if (div_rsp.done) state_next = F_PUSH;
      F_PUSH:   if (!q_full) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      started <= 1'b0;
      cur_row <= '0;
    end else begin
      state <= state_next;
      if (div_req.start) started <= 1'b1;
      else if (div_rsp.done) started <= 1'b0;
      if (accept && command == CMD_START) cur_row <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= command;
      col_r      <= column;
      row_r      <= row[TILE_BITS-1:0];
      color_r    <= color;
      in_range_r <= in_range;
    end
    if (div_rsp.done) begin
      unique case (state)
        F_SCALE:  divq   <= div_rsp.quot[7:0];
        F_DISP:   disp   <= div_rsp.quot[7:0];
        F_COLX:   colx   <= div_rsp.rem[TILE_BITS-1:0];
        F_SHIFTX: shiftx <= div_rsp.rem[TILE_BITS-1:0];
        F_ROWY:   rowy   <= div_rsp.rem[TILE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Convex split: left moves by floor(o/2), right by ceil(o/2).
  assign ol   = {1'b0, disp[7:1]};
  assign orr  = disp - ol;
  assign lsum = {1'b0, col_r} + {3'd0, ol};

  always_comb begin
    push_op = '0;
    push_op.kind = OP_CLEAR;
    unique case (cmd_r)
      CMD_LOAD_BG: begin
        push_op.kind  = OP_BG_WR;
        push_op.tex_a = {row_r, col_r[TILE_BITS-1:0]};
        push_op.color = color_r;
      end
      CMD_LOAD_FG: begin
        push_op.kind  = OP_FG_WR;
        push_op.tex_a = {row_r, col_r[TILE_BITS-1:0]};
        push_op.color = color_r;
      end
      CMD_START: push_op.kind = OP_CLEAR;
      CMD_DEPTH: begin
        push_op.kind = OP_PAINT;
        if (!mode) begin
          push_op.tex_a     = {rowy, colx};
          push_op.tex_b     = {rowy, colx};
          push_op.left_en   = lsum < w_eff;
          push_op.left_col  = lsum[COL_BITS-1:0];
          push_op.right_en  = col_r >= {2'd0, orr};
          push_op.right_col = col_r - {2'd0, orr};
        end else begin
          push_op.tex_a     = {rowy, shiftx};
          push_op.tex_b     = {rowy, colx};
          push_op.left_en   = 1'b1;
          push_op.left_col  = col_r;
          push_op.right_en  = 1'b1;
          push_op.right_col = col_r;
        end
      end
      CMD_READ: begin
        push_op.kind     = in_range_r ? OP_READ : OP_READ_ZERO;
        push_op.tex_a    = {rowy, colx};
        push_op.left_col = col_r;
      end
      default: ;
    endcase
  end

  assign push = (state == F_PUSH) && !q_full;

  `PSRB_CHECK_IMP(a_div_idle_on_start, div_req.start, !div_rsp.busy,
                  "divider started while busy")
  `PSRB_CHECK_NXT(a_row_latched, accept && command == CMD_START, cur_row == $past(row),
                  "start row not latched")

endmodule

`default_nettype wire

### design/psrb_queue.sv
// ---------------------------------------------------------------------------
// psrb_queue
// Short op queue between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pattern_stereogram_row_builder_defines.svh"

module psrb_queue import psrb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  input  wire logic pop,
  output op_t       head,
  output logic      full,
  output logic      empty
);

  op_t                  slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  `PSRB_CHECK_IMP(a_no_overflow, push, !full || pop, "push into full queue")
  `PSRB_CHECK_IMP(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

### design/psrb_back.sv
// ---------------------------------------------------------------------------
// psrb_back
// Owns tile and row memories; runs queued ops and drives the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pattern_stereogram_row_builder_defines.svh"

module psrb_back import psrb_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire op_t                 head,
  output logic                     pop,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [RGB_BITS-1:0]      left_color,
  output logic [RGB_BITS-1:0]      right_color
);

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_EXEC  = 3'b100
  } bstate_t;

  bstate_t state;

  logic [RGB_BITS-1:0] bg_mem    [TILE_SIDE*TILE_SIDE];
  logic [RGB_BITS-1:0] fg_mem    [TILE_SIDE*TILE_SIDE];
  logic [RGB_BITS:0]   left_mem  [MAX_WIDTH];   // {written, color}
  logic [RGB_BITS:0]   right_mem [MAX_WIDTH];

  op_t                 cur;
  logic [COL_BITS-1:0] clr_cnt;
  logic [RGB_BITS-1:0] bg_rd;
  logic [RGB_BITS-1:0] fg_rd_a;
  logic [RGB_BITS-1:0] fg_rd_b;
  logic [RGB_BITS:0]   left_rd;
  logic [RGB_BITS:0]   right_rd;

  logic                exec_paint;
  logic                out_free;
  logic                load_out;
  logic                lw_en;
  logic                rw_en;
  logic [COL_BITS-1:0] lw_addr;
  logic [COL_BITS-1:0] rw_addr;
  logic [RGB_BITS:0]   lw_data;
  logic [RGB_BITS:0]   rw_data;

  assign pop        = (state == B_IDLE) && !q_empty;
  assign exec_paint = (state == B_EXEC) && (cur.kind == OP_PAINT);
  assign out_free   = !result_valid || !result_stall;
  assign load_out   = (state == B_EXEC) && (cur.kind != OP_PAINT) && out_free;

  // Row memory write ports: clearing sweep or paint.
  always_comb begin
    lw_en   = 1'b0;
    rw_en   = 1'b0;
    lw_addr = cur.left_col;
    rw_addr = cur.right_col;
    lw_data = {1'b1, fg_rd_a};
    rw_data = {1'b1, fg_rd_b};
    if (state == B_CLEAR) begin
      lw_en   = 1'b1;
      rw_en   = 1'b1;
      lw_addr = clr_cnt;
      rw_addr = clr_cnt;
      lw_data = '0;
      rw_data = '0;
    end else if (exec_paint) begin
      lw_en = cur.left_en;
      rw_en = cur.right_en;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == OP_BG_WR) bg_mem[head.tex_a] <= head.color;
    if (pop) bg_rd <= bg_mem[head.tex_a];
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == OP_FG_WR) fg_mem[head.tex_a] <= head.color;
    if (pop) begin
      fg_rd_a <= fg_mem[head.tex_a];
      fg_rd_b <= fg_mem[head.tex_b];
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) left_mem[lw_addr] <= lw_data;
    if (pop) left_rd <= left_mem[head.left_col];
  end

  always_ff @(posedge clk) begin
    if (rw_en) right_mem[rw_addr] <= rw_data;
    if (pop) right_rd <= right_mem[head.left_col];
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == COL_BITS'(MAX_WIDTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (pop) begin
            if (head.kind == OP_CLEAR) begin
              state   <= B_CLEAR;
              clr_cnt <= '0;
            end else if (head.kind == OP_PAINT || head.kind == OP_READ
                         || head.kind == OP_READ_ZERO) begin
              state <= B_EXEC;
            end
          end
        end
        B_EXEC: begin
          if (exec_paint || load_out) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Unwritten columns show the background texel; out-of-range reads give zero.
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (cur.kind == OP_READ_ZERO) begin
        left_color  <= '0;
        right_color <= '0;
      end else begin
        left_color  <= left_rd[RGB_BITS]  ? left_rd[RGB_BITS-1:0]  : bg_rd;
        right_color <= right_rd[RGB_BITS] ? right_rd[RGB_BITS-1:0] : bg_rd;
      end
    end
  end

  `PSRB_CHECK_NXT(a_clear_ends, state == B_CLEAR && clr_cnt == COL_BITS'(MAX_WIDTH - 1),
                  state == B_IDLE, "clearing sweep did not end")

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereogram row builder: fills two rows of both
// tiles, then runs directed and random command bursts over several register
// settings while a scoreboard predicts every read-back pair of colors.
// ---------------------------------------------------------------------------

import psrb_pkg::*;

class row_scoreboard;
  typedef struct {
    logic [RGB_BITS-1:0] l;
    logic [RGB_BITS-1:0] r;
  } color_pair_t;

  logic [RGB_BITS-1:0] bg_tex[TILE_SIDE*TILE_SIDE];
  logic [RGB_BITS-1:0] fg_tex[TILE_SIDE*TILE_SIDE];
  logic [RGB_BITS-1:0] left_px[MAX_WIDTH];
  logic [RGB_BITS-1:0] right_px[MAX_WIDTH];
  bit                  left_set[MAX_WIDTH];
  bit                  right_set[MAX_WIDTH];
  logic [11:0]         cur_row;
  logic                concave;
  logic [7:0]          max_off;
  logic [10:0]         img_w;
  logic [6:0]          bg_w, bg_h, fg_w, fg_h;
  color_pair_t         pending_reads[$];
  int                  reads_checked;

  function new();
    cur_row = '0;
    concave = 1'b0;
    max_off = 8'd10;
    img_w   = 11'd1024;
    bg_w = 7'd64; bg_h = 7'd64; fg_w = 7'd64; fg_h = 7'd64;
    reads_checked = 0;
    foreach (left_set[i]) begin
      left_set[i]  = 1'b0;
      right_set[i] = 1'b0;
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [10:0] data);
    case (idx)
      REG_MODE:       concave = data[0];
      REG_MAX_OFFSET: max_off = data[7:0];
      REG_IMG_WIDTH:  img_w   = data;
      REG_BG_WIDTH:   bg_w    = data[6:0];
      REG_BG_HEIGHT:  bg_h    = data[6:0];
      REG_FG_WIDTH:   fg_w    = data[6:0];
      REG_FG_HEIGHT:  fg_h    = data[6:0];
      default: ;
    endcase
  endfunction

  function int side(logic [6:0] v);
    if (v == 0) return 1;
    if (v > TILE_SIDE) return TILE_SIDE;
    return v;
  endfunction

  function int width_now();
    return (img_w > MAX_WIDTH) ? MAX_WIDTH : int'(img_w);
  endfunction

  function logic [RGB_BITS-1:0] texel(bit from_fg, int x, int y);
    if (from_fg) return fg_tex[(y % side(fg_h)) * TILE_SIDE + (x % side(fg_w))];
    return bg_tex[(y % side(bg_h)) * TILE_SIDE + (x % side(bg_w))];
  endfunction

  function int shift_of(logic [RGB_BITS-1:0] c);
    int gray, mo, dv;
    gray = (11 * c[23:16] + 16 * c[15:8] + 5 * c[7:0]) >> 5;
    mo = (max_off == 0) ? 1 : max_off;
    dv = 255 / mo;
    return (2 * gray + dv) / (2 * dv);
  endfunction

  // Update the row state for one accepted transfer.
  function void note_item(logic [2:0] cmd, logic [9:0] col, logic [11:0] rw,
                          logic [RGB_BITS-1:0] c);
    int w, o, ol, orr;
    logic [RGB_BITS-1:0] fc, bgc;
    color_pair_t p;
    w = width_now();
    case (cmd)
      CMD_LOAD_BG, CMD_LOAD_FG: begin
        if (col < TILE_SIDE && rw < TILE_SIDE) begin
          if (cmd == CMD_LOAD_BG) bg_tex[rw * TILE_SIDE + col] = c;
          else fg_tex[rw * TILE_SIDE + col] = c;
        end
      end
      CMD_START: begin
        cur_row = rw;
        foreach (left_set[i]) begin
          left_set[i]  = 1'b0;
          right_set[i] = 1'b0;
        end
      end
      CMD_DEPTH: begin
        if (col < w) begin
          o = shift_of(c);
          if (o > 0) begin
            if (!concave) begin
              ol  = o / 2;
              orr = o - ol;
              fc  = texel(1'b1, col, cur_row);
              if (col + ol < w) begin
                left_px[col + ol]  = fc;
                left_set[col + ol] = 1'b1;
              end
              if (col >= orr) begin
                right_px[col - orr]  = fc;
                right_set[col - orr] = 1'b1;
              end
            end else begin
              left_px[col]   = texel(1'b1, col + o, cur_row);
              left_set[col]  = 1'b1;
              right_px[col]  = texel(1'b1, col, cur_row);
              right_set[col] = 1'b1;
            end
          end
        end
      end
      CMD_READ: begin
        p.l = '0;
        p.r = '0;
        if (col < w) begin
          bgc = texel(1'b0, col, cur_row);
          p.l = left_set[col] ? left_px[col] : bgc;
          p.r = right_set[col] ? right_px[col] : bgc;
        end
        pending_reads.push_back(p);
      end
      default: ;
    endcase
  endfunction

  function bit check_result(logic [RGB_BITS-1:0] l, logic [RGB_BITS-1:0] r,
                            output string why);
    color_pair_t p;
    why = "";
    if (pending_reads.size() == 0) begin
      why = $sformatf("unexpected result left=%06h right=%06h", l, r);
      return 1'b0;
    end
    p = pending_reads.pop_front();
    reads_checked++;
    if (l !== p.l) why = $sformatf("left_color %06h, want %06h ", l, p.l);
    if (r !== p.r) why = {why, $sformatf("right_color %06h, want %06h", r, p.r)};
    return why == "";
  endfunction

  function int pending();
    return pending_reads.size();
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 2500;
  localparam int FILL_ROWS = 2;
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [10:0]         cfg_data = '0;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [2:0]          command = '0;
  logic [COL_BITS-1:0] column = '0;
  logic [11:0]         row = '0;
  logic [RGB_BITS-1:0] color = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [RGB_BITS-1:0] left_color, right_color;

  row_scoreboard sb = new();
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_request = 0;
  int hold_left = 0;

  pattern_stereogram_row_builder dut (.*);

  always #1 clk = ~clk;

  task automatic report(string msg);
    errors++;
    $display("MISMATCH @%0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // Result side: check accepted transfers, pick the next stall.
  always @(posedge clk) begin
    string why;
    if (!rst && result_valid && !result_stall) begin
      if (!sb.check_result(left_color, right_color, why)) report(why);
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send(logic [2:0] cmd, int col, int rw, logic [RGB_BITS-1:0] c);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    column <= col[COL_BITS-1:0];
    row <= rw[11:0];
    color <= c;
    do @(posedge clk); while (item_stall);
    sb.note_item(cmd, col[COL_BITS-1:0], rw[11:0], c);
    items_sent++;
  endtask

  task automatic idle_sender();
    item_valid <= 1'b0;
  endtask

  // Wait for all reads back, then let the back end finish sweeping.
  task automatic settle();
    idle_sender();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Tile heights stay within the loaded rows.
  task automatic setup(logic md, logic [7:0] mo, logic [10:0] iw, logic [6:0] bw,
                       logic [6:0] bh, logic [6:0] fw, logic [6:0] fh);
    settle();
    write_reg(REG_MODE, {10'd0, md});
    write_reg(REG_MAX_OFFSET, {3'd0, mo});
    write_reg(REG_IMG_WIDTH, iw);
    write_reg(REG_BG_WIDTH, {4'd0, bw});
    write_reg(REG_BG_HEIGHT, {4'd0, bh});
    write_reg(REG_FG_WIDTH, {4'd0, fw});
    write_reg(REG_FG_HEIGHT, {4'd0, fh});
  endtask

  function automatic int pick_col();
    int w;
    w = sb.width_now();
    if (w == 0 || $urandom_range(9) == 0) return $urandom_range(1023);
    return $urandom_range(w - 1);
  endfunction

  // Start a row, paint a handful of neighbors, read back around them.
  task automatic row_burst();
    int base;
    base = pick_col();
    send(CMD_START, $urandom_range(1023), $urandom_range(4095), 24'($urandom));
    repeat ($urandom_range(3, 10)) begin
      send(CMD_DEPTH, (base + $urandom_range(12)) % 1024, $urandom_range(4095),
           24'($urandom));
    end
    for (int j = -4; j < 16; j++) begin
      if ($urandom_range(3) != 0) send(CMD_READ, (base + j + 1024) % 1024,
                                       $urandom_range(4095), 24'($urandom));
    end
  endtask

  task automatic noise_item();
    int k;
    k = $urandom_range(99);
    if (k < 8) send(CMD_LOAD_BG, $urandom_range(1023), $urandom_range(4095), 24'($urandom));
    else if (k < 16) send(CMD_LOAD_FG, $urandom_range(70), $urandom_range(70), 24'($urandom));
    else if (k < 50) send(CMD_DEPTH, pick_col(), $urandom_range(4095), 24'($urandom));
    else if (k < 95) send(CMD_READ, pick_col(), $urandom_range(4095), 24'($urandom));
    else send(3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)), $urandom_range(1023),
              $urandom_range(4095), 24'($urandom));
  endtask

  task automatic random_phase(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(3) != 0) row_burst();
      else repeat (6) noise_item();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the tile rows that any setting below can reach.
    for (int y = 0; y < FILL_ROWS; y++) begin
      for (int x = 0; x < TILE_SIDE; x++) begin
        send(CMD_LOAD_BG, x, y, 24'($urandom));
        send(CMD_LOAD_FG, x, y, 24'($urandom));
      end
    end

    send_idle = 25;
    recv_idle = 47;
    setup(0, 10, 1024, 64, 2, 64, 2);
    // Directed: ignored loads, spare commands, edge columns and depths.
    send(CMD_LOAD_BG, 64, 0, 24'hFFFFFF);
    send(CMD_LOAD_FG, 0, 64, 24'hFFFFFF);
    send(CMD_SPARE_A, 1023, 4095, 24'hFFFFFF);
    send(CMD_SPARE_B, 0, 0, 24'h0);
    send(CMD_SPARE_C, 512, 2048, 24'h800000);
    send(CMD_START, 0, 4095, 24'h0);
    send(CMD_DEPTH, 0, 0, 24'h000000);
    send(CMD_DEPTH, 5, 0, 24'hFFFFFF);
    send(CMD_DEPTH, 6, 0, 24'h808080);
    send(CMD_DEPTH, 1023, 0, 24'hFFFFFF);
    send(CMD_DEPTH, 6, 0, 24'hFF0000);
    for (int c = 0; c < 8; c++) send(CMD_READ, c, 0, 24'h0);
    send(CMD_READ, 1023, 0, 24'h0);
    send(CMD_READ, 1018, 0, 24'h0);
    random_phase(40);

    setup(0, 255, 2047, 127, 0, 7, 2);
    hold_request = 600;
    random_phase(40);

    send_idle = 47;
    recv_idle = 25;
    setup(1, 0, 100, 1, 1, 64, 2);
    send(CMD_DEPTH, 150, 0, 24'hFFFFFF);
    send(CMD_READ, 100, 0, 24'h0);
    random_phase(40);

    setup(1, 255, 1, 5, 2, 0, 2);
    random_phase(30);

    send_idle = 0;
    recv_idle = 0;
    setup(0, 37, 0, 13, 2, 33, 1);
    random_phase(25);

    setup(1, 128, 700, 17, 2, 50, 2);
    hold_request = 300;
    random_phase(45);

    settle();
    $display("ran %0d transfers over six register settings, both modes", items_sent);
    $display("checked %0d read-backs, %0d mismatches", sb.reads_checked, errors);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

### pattern_stereogram_row_builder.f
+incdir+design
design/psrb_pkg.sv
design/psrb_div.sv
design/psrb_front.sv
design/psrb_queue.sv
design/psrb_back.sv
design/pattern_stereogram_row_builder.sv
test/tb_top.sv
